// File: src/dmcd_pkg.sv
// Shared constants and types for the debounced multi-click detector.
`default_nettype none

package dmcd_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CountW   = 4;
  localparam int unsigned GestureW = 3;
  localparam int unsigned CfgIdxW  = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE    = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_MULTI_CLICK = 1'd1;

  localparam logic [CfgW-1:0] DEBOUNCE_RESET    = 16'd25;
  localparam logic [CfgW-1:0] MULTI_CLICK_RESET = 16'd500;

  // Gesture codes
  localparam logic [GestureW-1:0] GEST_NONE   = 3'd0;
  localparam logic [GestureW-1:0] GEST_SINGLE = 3'd1;
  localparam logic [GestureW-1:0] GEST_DOUBLE = 3'd2;
  localparam logic [GestureW-1:0] GEST_TRIPLE = 3'd3;
  localparam logic [GestureW-1:0] GEST_FOUR   = 3'd4;

  localparam logic [CountW-1:0] CLICK_MAX = 4'd15;

  localparam logic LEVEL_RELEASED = 1'b1;

  typedef logic [TimeW-1:0]    ms_t;
  typedef logic [CfgW-1:0]     cfg_word_t;
  typedef logic [CountW-1:0]   count_t;
  typedef logic [GestureW-1:0] gesture_t;

  // Map a click count to the reported gesture
  function automatic gesture_t count_to_gesture(input count_t cnt);
    gesture_t g;
    case (cnt)
      4'd0:    g = GEST_NONE;
      4'd1:    g = GEST_SINGLE;
      4'd2:    g = GEST_DOUBLE;
      4'd3:    g = GEST_TRIPLE;
      default: g = GEST_FOUR;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: src/dmcd_if.sv
// Valid/ready channel interfaces for button samples and detector results.
`default_nettype none

interface dmcd_sample_if;
  logic                  valid;
  logic                  ready;
  logic                  raw_level;
  logic [31:0]           now_ms;
  logic                  screen_on;

  modport source (output valid, output raw_level, output now_ms, output screen_on,
                  input ready);
  modport sink   (input valid, input raw_level, input now_ms, input screen_on,
                  output ready);
endinterface

interface dmcd_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] gesture;
  logic       wake_screen;

  modport source (output valid, output gesture, output wake_screen, input ready);
  modport sink   (input valid, input gesture, input wake_screen, output ready);
endinterface

`default_nettype wire

// File: src/debounced_multi_click_detector_unit.sv
// Top level of the debounced multi-click detector.
//
// Usage: each transaction on the sample channel carries one sample of an
// active-low button pin, a free-running millisecond timestamp and a
// screen-on flag. Every sample produces exactly one transaction on the
// result channel with a gesture code (none, single, double, triple, four or
// more) and a wake_screen flag.
// Path: an accepted sample waits in the input register, and its result is
// offered from the result register. Throughput: one sample per cycle while
// the result channel is not stalled; the whole update is a pair of 32-bit
// subtract-and-compare paths between the input register and result register.
// Stall: while the result channel is stalled the input register still takes
// one more sample; the sample channel drops ready only when both registers
// hold data.
// Reset: rst (synchronous, active high) empties both registers, restores
// debounce_ms to 25 and multi_click_ms to 500, and returns the button state
// to released with no pending clicks.
// Configuration: cfg_write with cfg_index/cfg_data, only while idle.
`default_nettype none

module debounced_multi_click_detector_unit (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [dmcd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [dmcd_pkg::CfgW-1:0]    cfg_data,
  dmcd_sample_if.sink                 sample,
  dmcd_result_if.source               result
);
  import dmcd_pkg::*;

  // Configuration registers
  cfg_word_t debounce_ms;
  cfg_word_t multi_click_ms;

  // Input register
  logic s1_valid;
  logic s1_raw;
  ms_t  s1_now;
  logic s1_screen;

  // Button state
  logic   prev_raw;
  logic   stable_level;
  ms_t    change_time;
  ms_t    release_time;
  count_t click_count;

  // Result register
  logic     out_valid;
  gesture_t out_gesture;
  logic     out_wake;

  // Next-state values computed from the input register
  ms_t      change_time_next;
  ms_t      release_time_next;
  count_t   click_count_next;
  logic     stable_level_next;
  gesture_t gesture_next;
  logic     wake_next;
  ms_t      held_ms;
  ms_t      idle_ms;
  logic     level_taken;
  logic     s1_advance;

  // Advance the input register when the result register is free or draining
  assign s1_advance   = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || s1_advance;

  assign result.valid       = out_valid;
  assign result.gesture     = out_gesture;
  assign result.wake_screen = out_wake;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms    <= DEBOUNCE_RESET;
      multi_click_ms <= MULTI_CLICK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEBOUNCE:    debounce_ms    <= cfg_data;
        REG_MULTI_CLICK: multi_click_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the sample; payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
    if (sample.valid && sample.ready) begin
      s1_raw    <= sample.raw_level;
      s1_now    <= sample.now_ms;
      s1_screen <= sample.screen_on;
    end
  end

  // One full update: debounce, release handling, then group close
  always_comb begin
    change_time_next  = (s1_raw != prev_raw) ? s1_now : change_time;
    held_ms           = s1_now - change_time_next;
    level_taken       = (held_ms > {{(TimeW-CfgW){1'b0}}, debounce_ms}) &&
                        (s1_raw != stable_level);
    stable_level_next = level_taken ? s1_raw : stable_level;
    release_time_next = release_time;
    click_count_next  = click_count;
    wake_next         = 1'b0;
    gesture_next      = GEST_NONE;

    if (level_taken && s1_raw == LEVEL_RELEASED) begin
      if (!s1_screen) begin
        // Release with the display off: wake it and drop any pending group
        wake_next        = 1'b1;
        click_count_next = '0;
      end else begin
        if (click_count < CLICK_MAX) begin
          click_count_next = click_count + count_t'(1);
        end
        release_time_next = s1_now;
      end
    end

    idle_ms = s1_now - release_time_next;
    if (click_count_next != '0 && idle_ms > {{(TimeW-CfgW){1'b0}}, multi_click_ms}) begin
      gesture_next     = count_to_gesture(click_count_next);
      click_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw     <= LEVEL_RELEASED;
      stable_level <= LEVEL_RELEASED;
      change_time  <= '0;
      release_time <= '0;
      click_count  <= '0;
    end else if (s1_advance) begin
      prev_raw     <= s1_raw;
      stable_level <= stable_level_next;
      change_time  <= change_time_next;
      release_time <= release_time_next;
      click_count  <= click_count_next;
    end
  end

  // Result register: load on advance, clear once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_advance) begin
      out_gesture <= gesture_next;
      out_wake    <= wake_next;
    end
  end

  // A wake clears the group, so no gesture can ride along with it
  a_wake_no_gesture: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_wake |-> out_gesture == GEST_NONE)
    else $error("wake reported together with a gesture");

  // Reported gesture codes stay within the defined set
  a_gesture_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_gesture <= GEST_FOUR)
    else $error("gesture code out of range");

  // Closing a group leaves no pending clicks
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    s1_advance && gesture_next != GEST_NONE |=> click_count == '0)
    else $error("click count not cleared after gesture");

  // Button state moves only when an item passes through
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_advance |=> $stable(stable_level) && $stable(click_count))
    else $error("button state changed without an item");

  // Both registers are empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("registers not empty after reset");

endmodule

`default_nettype wire
